// File: rtl/landing_stillness_detector_defines.svh
// Assertion macros shared by the landing stillness detector RTL.
// Clocked on clk_i; the reset-qualified form also needs rst_ni in scope.
`ifndef LANDING_STILLNESS_DETECTOR_DEFINES_SVH
`define LANDING_STILLNESS_DETECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LSD_ASSERT(lbl, prop, msg)
`define LSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/lsd_pkg.sv
// Types, register codes and constants for the landing stillness detector.
// No dependencies; imported by every module of the block.
`default_nettype none
package lsd_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] BlinkAfterMs = 32'd2000;

  // register indexes on the config port
  localparam logic [2:0] RegGyroLimit     = 3'd0;
  localparam logic [2:0] RegGyroHoldMs    = 3'd1;
  localparam logic [2:0] RegPressureLimit = 3'd2;
  localparam logic [2:0] RegPressureHold  = 3'd3;
  localparam logic [2:0] RegSubgoalMs     = 3'd4;
  localparam logic [2:0] RegAbortMs       = 3'd5;
  localparam logic [2:0] RegIntervalMs    = 3'd6;
  localparam logic [2:0] RegNavigating    = 3'd7;

  typedef enum logic [1:0] {
    CauseNone    = 2'd0,
    CauseBoth    = 2'd1,
    CauseSubgoal = 2'd2,
    CauseAbort   = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    LedNone  = 2'd0,
    LedBlink = 2'd1,
    LedReset = 2'd2
  } led_cue_e;

  typedef enum logic [1:0] {
    BuzzNone  = 2'd0,
    BuzzShort = 2'd1,
    BuzzLong  = 2'd2
  } buzz_cue_e;

  typedef enum logic {
    OpStart  = 1'b0,
    OpSample = 1'b1
  } op_e;

  typedef struct packed {
    logic               op;
    logic [31:0]        time_ms;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [23:0]        pressure;
  } lsd_in_t;

  typedef struct packed {
    logic      processed;
    logic      gyro_ok;
    logic      pressure_ok;
    logic      landed;
    cause_e    cause;
    logic      route_separate;
    led_cue_e  led_cue;
    buzz_cue_e buzz_cue;
  } lsd_out_t;

  // queued transaction: squares already formed by the front end
  typedef struct packed {
    op_e         op;
    logic [31:0] time_ms;
    logic [30:0] sq_x;
    logic [30:0] sq_y;
    logic [30:0] sq_z;
    logic [23:0] pressure;
  } lsd_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lsd_q_status_t;

  typedef struct packed {
    logic [29:0] gyro_lim2;
    logic [31:0] gyro_hold_ms;
    logic [23:0] pressure_limit;
    logic [31:0] pressure_hold_ms;
    logic [31:0] subgoal_ms;
    logic [31:0] abort_ms;
    logic [31:0] interval_ms;
    logic        navigating;
  } lsd_cfg_t;

endpackage
`default_nettype wire

// File: rtl/landing_stillness_detector.sv
// Top level of the landing stillness detector.
// Depends on lsd_pkg, lsd_regs, lsd_front, lsd_queue and lsd_back.
//
//  channel  handshake                  payload
//  in       in_valid_i / in_stall_o    in_data_i  (lsd_in_t)
//  out      out_valid_o / out_stall_i  out_data_o (lsd_out_t)
//  config   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction per cycle sustained while out_stall_i is low; an accepted transaction
// passes through the queue entry, then the decision register, before out_valid_o rises.
// The two-entry queue lets the input keep flowing while the output stalls, until the queue fills.
// Reset is asynchronous and clears all qualifier state; no clearing pass is needed.
// A register write takes effect at once; the squared gyro limit follows in the next cycle.
`default_nettype none
module landing_stillness_detector (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lsd_pkg::lsd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lsd_pkg::lsd_out_t      out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  import lsd_pkg::*;

  lsd_cfg_t      cfg;
  lsd_q_status_t q_status;
  lsd_entry_t    push_entry, pop_entry;
  logic          push, pop;

  lsd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  lsd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  lsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_status_i  (q_status),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: rtl/lsd_regs.sv
// Configuration register file on an APB-style port.
// Depends on lsd_pkg; also keeps the squared gyro limit registered.
`default_nettype none
module lsd_regs (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [4:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  output lsd_pkg::lsd_cfg_t    cfg_o
);
  import lsd_pkg::*;

  logic [14:0] gyro_limit_q;
  logic [31:0] gyro_hold_q;
  logic [23:0] press_limit_q;
  logic [31:0] press_hold_q;
  logic [31:0] subgoal_q;
  logic [31:0] abort_q;
  logic [31:0] interval_q;
  logic        nav_q;
  logic [29:0] lim2_q;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_limit_q  <= 15'd100;
      gyro_hold_q   <= 32'd5000;
      press_limit_q <= 24'd16;
      press_hold_q  <= 32'd5000;
      subgoal_q     <= 32'd60000;
      abort_q       <= 32'd300000;
      interval_q    <= 32'd1000;
      nav_q         <= 1'b0;
      lim2_q        <= 30'd10000;
    end else begin
      // lim2 follows next cycle; user must write only while idle; unenforced
      lim2_q <= gyro_limit_q * gyro_limit_q;
      if (wr_en) begin
        case (idx)
          RegGyroLimit:     gyro_limit_q  <= pwdata[14:0];
          RegGyroHoldMs:    gyro_hold_q   <= pwdata;
          RegPressureLimit: press_limit_q <= pwdata[23:0];
          RegPressureHold:  press_hold_q  <= pwdata;
          RegSubgoalMs:     subgoal_q     <= pwdata;
          RegAbortMs:       abort_q       <= pwdata;
          RegIntervalMs:    interval_q    <= pwdata;
          RegNavigating:    nav_q         <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      RegGyroLimit:     prdata = {17'd0, gyro_limit_q};
      RegGyroHoldMs:    prdata = gyro_hold_q;
      RegPressureLimit: prdata = {8'd0, press_limit_q};
      RegPressureHold:  prdata = press_hold_q;
      RegSubgoalMs:     prdata = subgoal_q;
      RegAbortMs:       prdata = abort_q;
      RegIntervalMs:    prdata = interval_q;
      RegNavigating:    prdata = {31'd0, nav_q};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg_o.gyro_lim2        = lim2_q;
    cfg_o.gyro_hold_ms     = gyro_hold_q;
    cfg_o.pressure_limit   = press_limit_q;
    cfg_o.pressure_hold_ms = press_hold_q;
    cfg_o.subgoal_ms       = subgoal_q;
    cfg_o.abort_ms         = abort_q;
    cfg_o.interval_ms      = interval_q;
    cfg_o.navigating       = nav_q;
  end

endmodule
`default_nettype wire

// File: rtl/lsd_front.sv
// Front end: accepts input transactions, classifies them and forms the gyro squares.
// Depends on lsd_pkg; pushes into lsd_queue.
`default_nettype none
module lsd_front (
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire lsd_pkg::lsd_in_t      in_data_i,
  input  wire lsd_pkg::lsd_q_status_t q_status_i,
  output logic                       push_o,
  output lsd_pkg::lsd_entry_t        entry_o
);
  import lsd_pkg::*;

  logic signed [31:0] px, py, pz;

  assign px = in_data_i.gyro_x * in_data_i.gyro_x;
  assign py = in_data_i.gyro_y * in_data_i.gyro_y;
  assign pz = in_data_i.gyro_z * in_data_i.gyro_z;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    entry_o.op       = in_data_i.op ? OpSample : OpStart;
    entry_o.time_ms  = in_data_i.time_ms;
    // squares are never negative and below 2^31
    entry_o.sq_x     = px[30:0];
    entry_o.sq_y     = py[30:0];
    entry_o.sq_z     = pz[30:0];
    entry_o.pressure = in_data_i.pressure;
  end

endmodule
`default_nettype wire

// File: rtl/lsd_queue.sv
// Two-entry queue between front and back ends.
// Depends on lsd_pkg and the assertion macros header.
`default_nettype none
`include "landing_stillness_detector_defines.svh"
module lsd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire lsd_pkg::lsd_entry_t entry_i,
  input  wire logic                pop_i,
  output lsd_pkg::lsd_entry_t      entry_o,
  output lsd_pkg::lsd_q_status_t   status_o
);
  import lsd_pkg::*;

  lsd_entry_t mem_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign status_o.empty = (count_q == 2'd0);
  assign status_o.full  = (count_q == 2'(QueueDepth));
  assign entry_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  `LSD_ASSERT(q_no_overflow, push_i |-> !status_o.full, "push into full queue")
  `LSD_ASSERT(q_no_underflow, pop_i |-> !status_o.empty, "pop from empty queue")
  `LSD_ASSERT(q_count_range, count_q <= 2'(QueueDepth), "queue count out of range")

endmodule
`default_nettype wire

// File: rtl/lsd_back.sv
// Back end: qualifier state, landing decision and the output register.
// Depends on lsd_pkg and the assertion macros header; pops lsd_queue.
`default_nettype none
`include "landing_stillness_detector_defines.svh"
module lsd_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lsd_pkg::lsd_cfg_t      cfg_i,
  input  wire lsd_pkg::lsd_q_status_t q_status_i,
  input  wire lsd_pkg::lsd_entry_t    entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output lsd_pkg::lsd_out_t           out_data_o
);
  import lsd_pkg::*;

  logic        done_q, done_d;
  logic [31:0] fall_start_q, fall_start_d;
  logic [31:0] last_upd_q, last_upd_d;
  logic        g_run_q, g_run_d;
  logic [31:0] g_start_q, g_start_d;
  logic        g_lat_q, g_lat_d;
  logic        p_run_q, p_run_d;
  logic [31:0] p_start_q, p_start_d;
  logic        p_lat_q, p_lat_d;
  logic [23:0] ref_p_q, ref_p_d;

  logic        out_valid_q;
  lsd_out_t    out_q, res;

  logic [31:0] mag2, since_upd, g_held, p_held, elapsed;
  logic [23:0] p_diff;
  logic        gated_ok;

  assign pop_o       = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mag2      = {1'b0, entry_i.sq_x} + {1'b0, entry_i.sq_y} + {1'b0, entry_i.sq_z};
  assign since_upd = entry_i.time_ms - last_upd_q;
  assign g_held    = entry_i.time_ms - g_start_q;
  assign p_held    = entry_i.time_ms - p_start_q;
  assign elapsed   = entry_i.time_ms - fall_start_q;
  assign p_diff    = (entry_i.pressure >= ref_p_q) ? entry_i.pressure - ref_p_q
                                                   : ref_p_q - entry_i.pressure;
  assign gated_ok  = !done_q && (since_upd >= cfg_i.interval_ms);

  always_comb begin
    done_d       = done_q;
    fall_start_d = fall_start_q;
    last_upd_d   = last_upd_q;
    g_run_d      = g_run_q;
    g_start_d    = g_start_q;
    g_lat_d      = g_lat_q;
    p_run_d      = p_run_q;
    p_start_d    = p_start_q;
    p_lat_d      = p_lat_q;
    ref_p_d      = ref_p_q;
    res.processed = 1'b0;
    res.cause     = CauseNone;
    res.led_cue   = LedNone;
    res.buzz_cue  = BuzzNone;

    if (entry_i.op == OpStart) begin
      fall_start_d = entry_i.time_ms;
      last_upd_d   = entry_i.time_ms;
      ref_p_d      = entry_i.pressure;
      done_d       = 1'b0;
      g_run_d      = 1'b0;
      p_run_d      = 1'b0;
      g_lat_d      = 1'b0;
      p_lat_d      = 1'b0;
    end else if (gated_ok) begin
      res.processed = 1'b1;
      last_upd_d    = entry_i.time_ms;

      if (!g_lat_q) begin
        if (!g_run_q) begin
          g_start_d = entry_i.time_ms;
          g_run_d   = 1'b1;
        end else if (mag2 < {2'b00, cfg_i.gyro_lim2}) begin
          if (g_held > BlinkAfterMs) res.led_cue = LedBlink;
          if (g_held > cfg_i.gyro_hold_ms) begin
            g_lat_d = 1'b1;
            g_run_d = 1'b0;
          end
        end else begin
          g_run_d     = 1'b0;
          res.led_cue = LedReset;
        end
      end

      if (!p_lat_q) begin
        if (!p_run_q) begin
          p_start_d = entry_i.time_ms;
          p_run_d   = 1'b1;
        end else begin
          ref_p_d = entry_i.pressure;
          if (p_diff < cfg_i.pressure_limit) begin
            if (p_held > cfg_i.pressure_hold_ms) begin
              p_lat_d      = 1'b1;
              p_run_d      = 1'b0;
              res.buzz_cue = BuzzLong;
            end else begin
              res.buzz_cue = BuzzShort;
            end
          end else begin
            p_run_d = 1'b0;
          end
        end
      end

      if (g_lat_d && p_lat_d) begin
        res.cause = CauseBoth;
      end else if ((elapsed > cfg_i.subgoal_ms) && (g_lat_d || p_lat_d)) begin
        res.cause = CauseSubgoal;
      end else if (elapsed > cfg_i.abort_ms) begin
        res.cause = CauseAbort;
      end
      if (res.cause != CauseNone) done_d = 1'b1;
    end

    res.gyro_ok        = g_lat_d;
    res.pressure_ok    = p_lat_d;
    res.landed         = done_d;
    res.route_separate = cfg_i.navigating;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q       <= 1'b0;
      fall_start_q <= 32'd0;
      last_upd_q   <= 32'd0;
      g_run_q      <= 1'b0;
      g_start_q    <= 32'd0;
      g_lat_q      <= 1'b0;
      p_run_q      <= 1'b0;
      p_start_q    <= 32'd0;
      p_lat_q      <= 1'b0;
      ref_p_q      <= 24'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        done_q       <= done_d;
        fall_start_q <= fall_start_d;
        last_upd_q   <= last_upd_d;
        g_run_q      <= g_run_d;
        g_start_q    <= g_start_d;
        g_lat_q      <= g_lat_d;
        p_run_q      <= p_run_d;
        p_start_q    <= p_start_d;
        p_lat_q      <= p_lat_d;
        ref_p_q      <= ref_p_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= res;
  end

  `LSD_ASSERT(bk_cause_lands, out_valid_q && (out_q.cause != CauseNone) |->
    out_q.landed && out_q.processed, "decision without landing")
  `LSD_ASSERT(bk_gyro_lat_idle, g_lat_q |-> !g_run_q, "gyro latched while timing")
  `LSD_ASSERT(bk_press_lat_idle, p_lat_q |-> !p_run_q, "pressure latched while timing")

endmodule
`default_nettype wire
